/* src/pec_pkg.sv */
// Shared types, codes and character helpers for the percent escape codec.
`default_nettype none
package pec_pkg;

	// Character constants
	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam logic [7:0] CHAR_0   = 8'h30;
	localparam logic [7:0] CHAR_9   = 8'h39;
	localparam logic [7:0] CHAR_UA  = 8'h41;
	localparam logic [7:0] CHAR_UZ  = 8'h5a;
	localparam logic [7:0] CHAR_LA  = 8'h61;
	localparam logic [7:0] CHAR_LF  = 8'h66;
	localparam logic [7:0] CHAR_LZ  = 8'h7a;

	// Mode register codes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Result count per item, 0 to 3
	localparam int MAX_RESULTS = 3;
	typedef logic [1:0] res_count_t;

	// Position inside a percent escape
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HI   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       error;
	} out_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] high_nibble;
		logic       failed;
	} dec_state_t;

	typedef struct packed {
		out_item_t  r2;
		out_item_t  r1;
		out_item_t  r0;
		res_count_t count;
	} step_res_t;

	localparam dec_state_t DEC_STATE_RESET = '{phase: PH_IDLE, high_nibble: 4'h0, failed: 1'b0};

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_val_t;

	// Lowercase hex digit for a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CHAR_0 + {4'h0, v};
		end else begin
			c = CHAR_LA + {4'h0, v} - 8'd10;
		end
		return c;
	endfunction

	// Value of a lowercase hex digit, ok low for anything else
	function automatic hex_val_t hex_val(input logic [7:0] c);
		hex_val_t r;
		r = '{ok: 1'b0, value: 4'h0};
		if (c >= CHAR_0 && c <= CHAR_9) begin
			r.ok = 1'b1;
			r.value = c[3:0];
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			r.ok = 1'b1;
			r.value = c[3:0] + 4'd9;
		end
		return r;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
			(c >= CHAR_LA && c <= CHAR_LZ);
	endfunction

endpackage
`default_nettype wire

/* src/pec_step.sv */
// Per-byte encode/decode logic: results and next escape state for one item.
`default_nettype none
module pec_step (
	input  wire logic               mode,
	input  wire pec_pkg::in_item_t  item,
	input  wire pec_pkg::dec_state_t st,
	output pec_pkg::step_res_t      res,
	output pec_pkg::dec_state_t     st_next
);

	pec_pkg::hex_val_t hv;
	logic              err;

	assign hv = pec_pkg::hex_val(item.in_byte);

	// Work out the results and the state left behind
	always_comb begin
		res     = '0;
		st_next = st;
		err     = 1'b0;
		if (mode == pec_pkg::MODE_ENCODE) begin
			if (pec_pkg::is_alnum(item.in_byte)) begin
				res.r0    = '{out_byte: item.in_byte, last_of_run: 1'b1, error: 1'b0};
				res.count = 2'd1;
			end else begin
				res.r0    = '{out_byte: pec_pkg::PCT_CHAR, last_of_run: 1'b0, error: 1'b0};
				res.r1    = '{out_byte: pec_pkg::hex_char(item.in_byte[7:4]),
					last_of_run: 1'b0, error: 1'b0};
				res.r2    = '{out_byte: pec_pkg::hex_char(item.in_byte[3:0]),
					last_of_run: 1'b1, error: 1'b0};
				res.count = 2'd3;
			end
		end else if (!st.failed) begin
			case (st.phase)
				pec_pkg::PH_PCT: begin
					if (!hv.ok) begin
						err = 1'b1;
					end else begin
						st_next.high_nibble = hv.value;
						st_next.phase       = pec_pkg::PH_HI;
						err                 = item.end_of_string;
					end
				end
				pec_pkg::PH_HI: begin
					if (!hv.ok) begin
						err = 1'b1;
					end else begin
						res.r0 = '{out_byte: {st.high_nibble, hv.value}, last_of_run: 1'b1,
							error: 1'b0};
						res.count           = 2'd1;
						st_next.phase       = pec_pkg::PH_IDLE;
						st_next.high_nibble = 4'h0;
					end
				end
				default: begin
					st_next.phase = pec_pkg::PH_IDLE;
					if (item.in_byte == pec_pkg::PCT_CHAR) begin
						st_next.phase = pec_pkg::PH_PCT;
						err           = item.end_of_string;
					end else begin
						res.r0    = '{out_byte: item.in_byte, last_of_run: 1'b1, error: 1'b0};
						res.count = 2'd1;
					end
				end
			endcase
			// Replace any result by one error result and drop the rest of the string
			if (err) begin
				res.r0              = '{out_byte: 8'h00, last_of_run: 1'b1, error: 1'b1};
				res.count           = 2'd1;
				st_next.phase       = pec_pkg::PH_IDLE;
				st_next.high_nibble = 4'h0;
				st_next.failed      = 1'b1;
			end
		end
		// Clear the escape state at every end of string
		if (item.end_of_string) begin
			st_next = pec_pkg::DEC_STATE_RESET;
		end
	end

endmodule
`default_nettype wire

/* src/pec_out_buf.sv */
// Result register of up to three results, shifted out one per transfer.
`default_nettype none
module pec_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire pec_pkg::step_res_t  res,
	output logic                     load_ok,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pec_pkg::out_item_t       out_data
);

	pec_pkg::out_item_t  slot_q [pec_pkg::MAX_RESULTS];
	pec_pkg::res_count_t cnt_q;
	logic                xfer;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[0];
	assign xfer      = out_valid && out_ready;
	// Take a new set once the last held result leaves
	assign load_ok   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	// Track how many results remain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && load_ok) begin
			cnt_q <= res.count;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load or shift the result slots
	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			slot_q[0] <= res.r0;
			slot_q[1] <= res.r1;
			slot_q[2] <= res.r2;
		end else if (xfer) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3 || !out_valid || !slot_q[0].last_of_run)
		else $error("last result not at the tail of the run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !out_data.last_of_run) |=> out_valid)
		else $error("run broken off before its last result");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.error) |-> (out_data.last_of_run && out_data.out_byte == 8'h00))
		else $error("malformed error result");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_of_run) |-> (cnt_q == 2'd1))
		else $error("results held beyond the last of a run");

endmodule
`default_nettype wire

/* src/percent_escape_codec_unit.sv */
// Top level of the percent escape codec: input register, step logic and result register.
//
// Byte-stream percent codec. With mode 0 each byte that is not an ASCII letter or digit
// becomes '%' and two lowercase hex digits; with mode 1 escapes are turned back into bytes
// and a bad or truncated escape gives one error result, after which the rest of the string
// is dropped. Each byte passes the input register, then the result register; the block
// takes one byte per cycle when each byte gives at most one result and out_ready is high,
// and an encoded escape holds the input for three output transfers, as the result register
// releases one result per cycle while ready. Write mode only while no bytes are in flight.
`default_nettype none
module percent_escape_codec_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pec_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pec_pkg::out_item_t      out_data
);

	logic                mode_q;
	logic                valid_s1;
	pec_pkg::in_item_t   item_s1;
	pec_pkg::dec_state_t st_q;
	pec_pkg::dec_state_t st_next;
	pec_pkg::step_res_t  res;
	logic                load_ok;
	logic                advance;

	assign advance  = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || load_ok;

	// Hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pec_pkg::MODE_ENCODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Input register valid and escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= pec_pkg::DEC_STATE_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				st_q <= st_next;
			end
		end
	end

	// Capture the input payload on a transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	pec_step u_step (
		.mode    (mode_q),
		.item    (item_s1),
		.st      (st_q),
		.res     (res),
		.st_next (st_next)
	);

	pec_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.end_of_string) |=> (st_q == pec_pkg::DEC_STATE_RESET))
		else $error("escape state not cleared at end of string");

	a_encode_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == pec_pkg::MODE_ENCODE && !item_s1.end_of_string) |=>
		$stable(st_q))
		else $error("encode mode changed the decode state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_ok) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled item");

endmodule
`default_nettype wire

/* sim/percent_escape_codec_unit_tb.sv */
// Self-checking testbench for the percent escape codec: directed table, random strings, scoreboard.
`default_nettype none
module percent_escape_codec_unit_tb;

	localparam int PREDICTED     = -1;
	localparam int CHUNKS        = 6;
	localparam int CHUNK_ITEMS   = 14;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam logic [4:0] NOT_HEX = 5'd16;
	localparam pec_pkg::out_item_t ERR_RESULT = '{out_byte: 8'h00, last_of_run: 1'b1,
		error: 1'b1};
	localparam pec_pkg::out_item_t NO_RESULT  = '0;

	// One byte to offer, with its results typed in where they are plain to see
	typedef struct {
		logic               mode;
		pec_pkg::in_item_t  item;
		int                 n_typed;
		pec_pkg::out_item_t r0;
		pec_pkg::out_item_t r1;
		pec_pkg::out_item_t r2;
	} byte_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	pec_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	pec_pkg::out_item_t out_data;

	// Handshake outputs sampled on each falling edge, ahead of the next rising edge
	logic               in_ready_q = 1'b0;
	logic               out_valid_q = 1'b0;
	pec_pkg::out_item_t out_data_q = '0;

	// Predictor copy of the mode register and decode state
	logic            codec_mode;
	pec_pkg::phase_t dec_phase;
	logic [3:0]      dec_high;
	logic            dec_failed;

	byte_row_t          dir_rows[$];
	byte_row_t          offered_bytes_q[$];
	pec_pkg::out_item_t coded_bytes_q[$];

	int  src_idle_pct = 0;
	int  sink_idle_pct = 0;
	bit  hold_req = 1'b0;
	int  mismatch_count = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  error_results = 0;
	int  escapes_seen = 0;
	int  idle_cycles = 0;

	percent_escape_codec_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		in_ready_q  <= in_ready;
		out_valid_q <= out_valid;
		out_data_q  <= out_data;
	end

	function automatic logic [7:0] hex_ascii(input logic [3:0] v);
		string digits;
		digits = "0123456789abcdef";
		return digits[v];
	endfunction

	// Value of a lowercase hex digit, NOT_HEX for anything else
	function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
		if (c >= pec_pkg::CHAR_0 && c <= pec_pkg::CHAR_9) begin
			return {1'b0, c[3:0]};
		end
		if (c >= pec_pkg::CHAR_LA && c <= pec_pkg::CHAR_LF) begin
			return 5'(c - pec_pkg::CHAR_LA) + 5'd10;
		end
		return NOT_HEX;
	endfunction

	function automatic logic plain_char(input logic [7:0] c);
		return (c >= pec_pkg::CHAR_0 && c <= pec_pkg::CHAR_9) ||
			(c >= pec_pkg::CHAR_UA && c <= pec_pkg::CHAR_UZ) ||
			(c >= pec_pkg::CHAR_LA && c <= pec_pkg::CHAR_LZ);
	endfunction

	// Advance the predictor by one byte; returns how many results it yields
	function automatic int predict_codec_results(input pec_pkg::in_item_t it,
		output pec_pkg::out_item_t res [3]);
		logic [4:0] v;
		bit         bad;
		int         n;
		n = 0;
		bad = 1'b0;
		res[0] = NO_RESULT;
		res[1] = NO_RESULT;
		res[2] = NO_RESULT;
		if (codec_mode == pec_pkg::MODE_ENCODE) begin
			if (plain_char(it.in_byte)) begin
				res[0] = {it.in_byte, 1'b1, 1'b0};
				n = 1;
			end else begin
				res[0] = {pec_pkg::PCT_CHAR, 1'b0, 1'b0};
				res[1] = {hex_ascii(it.in_byte[7:4]), 1'b0, 1'b0};
				res[2] = {hex_ascii(it.in_byte[3:0]), 1'b1, 1'b0};
				n = 3;
			end
		end else if (!dec_failed) begin
			case (dec_phase)
				pec_pkg::PH_PCT: begin
					v = hex_digit_value(it.in_byte);
					if (v == NOT_HEX) begin
						bad = 1'b1;
					end else begin
						dec_high = v[3:0];
						dec_phase = pec_pkg::PH_HI;
						if (it.end_of_string) bad = 1'b1;
					end
				end
				pec_pkg::PH_HI: begin
					v = hex_digit_value(it.in_byte);
					if (v == NOT_HEX) begin
						bad = 1'b1;
					end else begin
						res[0] = {dec_high, v[3:0], 1'b1, 1'b0};
						n = 1;
						dec_phase = pec_pkg::PH_IDLE;
						dec_high = 4'h0;
					end
				end
				default: begin
					dec_phase = pec_pkg::PH_IDLE;
					if (it.in_byte == pec_pkg::PCT_CHAR) begin
						dec_phase = pec_pkg::PH_PCT;
						if (it.end_of_string) bad = 1'b1;
					end else begin
						res[0] = {it.in_byte, 1'b1, 1'b0};
						n = 1;
					end
				end
			endcase
			if (bad) begin
				res[0] = ERR_RESULT;
				n = 1;
				dec_phase = pec_pkg::PH_IDLE;
				dec_high = 4'h0;
				dec_failed = 1'b1;
			end
		end
		// Clear the decode state at every string end
		if (it.end_of_string) begin
			dec_phase = pec_pkg::PH_IDLE;
			dec_high = 4'h0;
			dec_failed = 1'b0;
		end
		return n;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Predict on each input transfer, check each output transfer, watch for a hang
	always @(posedge clk) begin : scoreboard
		bit                 moved;
		int                 n;
		pec_pkg::out_item_t res [3];
		pec_pkg::out_item_t got;
		pec_pkg::out_item_t want;
		byte_row_t          row;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && in_ready_q) begin
				moved = 1'b1;
				if (offered_bytes_q.size() == 0) begin
					flag_mismatch("input transfer with no byte on offer");
				end else begin
					row = offered_bytes_q.pop_front();
					n = predict_codec_results(row.item, res);
					if (row.n_typed != PREDICTED) begin
						n = row.n_typed;
						res[0] = row.r0;
						res[1] = row.r1;
						res[2] = row.r2;
					end
					for (int k = 0; k < n; k++) coded_bytes_q.push_back(res[k]);
				end
			end
			if (out_valid_q && out_ready) begin
				moved = 1'b1;
				got = out_data_q;
				results_checked++;
				if (got.error) error_results++;
				if (got.out_byte == pec_pkg::PCT_CHAR && !got.last_of_run && !got.error)
					escapes_seen++;
				if (coded_bytes_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result byte %h last %b error %b",
						got.out_byte, got.last_of_run, got.error));
				end else begin
					want = coded_bytes_q.pop_front();
					if (got.out_byte !== want.out_byte)
						flag_mismatch($sformatf("out_byte %h, expected %h",
							got.out_byte, want.out_byte));
					if (got.last_of_run !== want.last_of_run)
						flag_mismatch($sformatf("last_of_run %b, expected %b (byte %h)",
							got.last_of_run, want.last_of_run, want.out_byte));
					if (got.error !== want.error)
						flag_mismatch($sformatf("error %b, expected %b (byte %h)",
							got.error, want.error, want.out_byte));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic add_row(input logic m, input logic [7:0] b, input logic eos, input int n,
		input pec_pkg::out_item_t r0, input pec_pkg::out_item_t r1,
		input pec_pkg::out_item_t r2);
		byte_row_t row;
		row.mode = m;
		row.item = {b, eos};
		row.n_typed = n;
		row.r0 = r0;
		row.r1 = r1;
		row.r2 = r2;
		dir_rows.push_back(row);
	endtask

	// Offer one byte and hold it until the transfer
	task automatic offer_byte(input byte_row_t row);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= row.item;
		offered_bytes_q.push_back(row);
		@(posedge clk);
		while (!in_ready_q) @(posedge clk);
		items_sent++;
	endtask

	task automatic offer_random(input logic [7:0] b, input logic eos);
		byte_row_t row;
		row.mode = codec_mode;
		row.item = {b, eos};
		row.n_typed = PREDICTED;
		row.r0 = NO_RESULT;
		row.r1 = NO_RESULT;
		row.r2 = NO_RESULT;
		offer_byte(row);
	endtask

	// Stop offering, wait for every result, then let dropped bytes leave the pipeline
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (coded_bytes_q.size() != 0 || offered_bytes_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		codec_mode = m;
	endtask

	// One random string: random bytes and lowercase letters in encode, mostly well-formed escapes in decode
	task automatic send_string();
		logic [7:0] bytes_q[$];
		logic [7:0] b;
		int         len;
		len = $urandom_range(1, 6);
		if (codec_mode == pec_pkg::MODE_ENCODE) begin
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom_range(255));
				if ($urandom_range(1) == 0) b = pec_pkg::CHAR_LA + 8'($urandom_range(25));
				bytes_q.push_back(b);
			end
		end else if ($urandom_range(3) != 0) begin
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(2) == 0) begin
					bytes_q.push_back(pec_pkg::PCT_CHAR);
					bytes_q.push_back(hex_ascii(4'($urandom_range(15))));
					bytes_q.push_back(hex_ascii(4'($urandom_range(15))));
				end else begin
					b = 8'($urandom_range(255));
					if (b == pec_pkg::PCT_CHAR) b = pec_pkg::CHAR_UA;
					bytes_q.push_back(b);
				end
			end
		end else begin
			// Noise: stray percents, uppercase digits and cut-off escapes
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(3))
					0: b = pec_pkg::PCT_CHAR;
					1: b = hex_ascii(4'($urandom_range(15)));
					2: b = pec_pkg::CHAR_UA + 8'($urandom_range(5));
					default: b = 8'($urandom_range(255));
				endcase
				bytes_q.push_back(b);
			end
		end
		foreach (bytes_q[i]) offer_random(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	initial begin : stimulus
		int  chunk_start;
		bit  paused;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = pec_pkg::MODE_ENCODE;
		in_valid = 1'b0;
		in_data = '0;
		codec_mode = pec_pkg::MODE_ENCODE;
		dec_phase = pec_pkg::PH_IDLE;
		dec_high = 4'h0;
		dec_failed = 1'b0;

		// Encode: pass-through, byte extremes, percent itself
		add_row(pec_pkg::MODE_ENCODE, 8'h41, 1'b0, 1, {8'h41, 1'b1, 1'b0}, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_ENCODE, 8'h00, 1'b0, 3, {pec_pkg::PCT_CHAR, 1'b0, 1'b0},
			{8'h30, 1'b0, 1'b0}, {8'h30, 1'b1, 1'b0});
		add_row(pec_pkg::MODE_ENCODE, 8'hff, 1'b1, 3, {pec_pkg::PCT_CHAR, 1'b0, 1'b0},
			{8'h66, 1'b0, 1'b0}, {8'h66, 1'b1, 1'b0});
		add_row(pec_pkg::MODE_ENCODE, 8'h7a, 1'b0, PREDICTED, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_ENCODE, 8'h39, 1'b1, PREDICTED, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_ENCODE, 8'h80, 1'b0, PREDICTED, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_ENCODE, pec_pkg::PCT_CHAR, 1'b1, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		// Decode: full escape, raw extremes
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b0, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h66, 1'b0, 0, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h66, 1'b1, 1, {8'hff, 1'b1, 1'b0}, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h00, 1'b0, 1, {8'h00, 1'b1, 1'b0}, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'hff, 1'b1, 1, {8'hff, 1'b1, 1'b0}, NO_RESULT,
			NO_RESULT);
		// Bad digit mid-string, then the rest of the string is dropped
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b0, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h47, 1'b0, 1, ERR_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h61, 1'b0, 0, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h62, 1'b1, 0, NO_RESULT, NO_RESULT, NO_RESULT);
		// Truncated escapes and an uppercase digit on the end-marked byte
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b1, 1, ERR_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b0, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h61, 1'b1, 1, ERR_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b0, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h41, 1'b1, 1, ERR_RESULT, NO_RESULT, NO_RESULT);
		// Mode change mid-escape keeps the decode state
		add_row(pec_pkg::MODE_DECODE, pec_pkg::PCT_CHAR, 1'b0, PREDICTED, NO_RESULT, NO_RESULT,
			NO_RESULT);
		add_row(pec_pkg::MODE_ENCODE, 8'h71, 1'b0, PREDICTED, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h34, 1'b0, PREDICTED, NO_RESULT, NO_RESULT, NO_RESULT);
		add_row(pec_pkg::MODE_DECODE, 8'h31, 1'b1, 1, {8'h41, 1'b1, 1'b0}, NO_RESULT,
			NO_RESULT);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		src_idle_pct = 32;
		sink_idle_pct = 46;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != codec_mode) set_mode(dir_rows[i].mode);
			offer_byte(dir_rows[i]);
		end

		// Random strings, alternating mode, three idling profiles
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk / 2)
				0: begin src_idle_pct = 32; sink_idle_pct = 46; end
				1: begin src_idle_pct = 46; sink_idle_pct = 32; end
				default: begin src_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			set_mode((chunk % 2 == 0) ? pec_pkg::MODE_ENCODE : pec_pkg::MODE_DECODE);
			if (chunk == 0 || chunk == 3) hold_req = 1'b1;
			chunk_start = items_sent;
			paused = 1'b0;
			while (items_sent - chunk_start < CHUNK_ITEMS) begin
				send_string();
				if (!paused && items_sent - chunk_start >= CHUNK_ITEMS / 2) begin
					drain_and_settle();
					paused = 1'b1;
				end
			end
		end

		drain_and_settle();
		$display("Run covered %0d bytes in both modes, %0d results checked", items_sent,
			results_checked);
		$display("including %0d escape runs, %0d decode errors, back-pressure and pauses",
			escapes_seen, error_results);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
